@@ design/echo_ranging_pi_motor_drive_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the echo ranging PI motor drive
// Concurrent checks sampled on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ECHO_RANGING_PI_MOTOR_DRIVE_MACROS_SVH
`define ECHO_RANGING_PI_MOTOR_DRIVE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ERPMD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ERPMD_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/erpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// erpmd_pkg
// Shared widths, codes and types of the echo ranging PI motor drive.
// ----------------------------------------------------------------------------
package erpmd_pkg;

  // Field widths.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned DistW   = 8;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned GainW   = 8;
  localparam int unsigned IntegW  = 32;
  localparam int unsigned ErrW    = 9;
  localparam int unsigned PropW   = 17;
  localparam int unsigned ProdW   = 40;
  localparam int unsigned QuotW   = 17;
  localparam int unsigned DriveW  = 19;

  // Configuration port.
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // Event codes.
  localparam logic [ModeW-1:0] ModeEcho     = 2'd0;
  localparam logic [ModeW-1:0] ModeOverflow = 2'd1;
  localparam logic [ModeW-1:0] ModeTick     = 2'd2;

  // Register indexes.
  localparam logic [1:0] RegSetpoint = 2'd0;
  localparam logic [1:0] RegEnable   = 2'd1;
  localparam logic [1:0] RegGainP    = 2'd2;
  localparam logic [1:0] RegGainI    = 2'd3;

  // Register reset values.
  localparam logic [DistW-1:0] SetpointReset = 8'd100;
  localparam logic [GainW-1:0] GainPReset    = 8'd2;
  localparam logic [GainW-1:0] GainIReset    = 8'd0;

  // Rails and saturation limits.
  localparam logic [LevelW-1:0]        LevelMax  = 8'd255;
  localparam logic [DistW-1:0]         DistMax   = 8'd255;
  localparam logic signed [IntegW-1:0] IntegMax  = 32'sh7FFF_FFFF;
  localparam logic signed [IntegW-1:0] IntegMin  = 32'sh8000_0000;
  localparam logic signed [DriveW-1:0] DriveHigh = 19'sd255;
  localparam logic signed [DriveW-1:0] DriveLow  = -19'sd255;

  // Integral term divided by 100: magnitudes at or above 100 * 65536 are
  // clamped, since they already drive the output onto a rail. Below that
  // a multiply by ceil(2^30 / 100) and a shift by 30 is exact.
  localparam logic [ProdW-1:0] QuotLimit    = 40'd6553600;
  localparam logic [QuotW-1:0] QuotClamp    = 17'd65536;
  localparam int unsigned      RecipShift   = 30;
  localparam int unsigned      RecipW       = 24;
  localparam int unsigned      RecipInW     = 23;
  localparam logic [RecipW-1:0] RecipHundred = 24'd10737419;

  // Configuration registers.
  typedef struct packed {
    logic [DistW-1:0] setpoint;
    logic             enable;
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
  } erpmd_cfg_t;

  // Pipeline register between the front stage and the drive stage.
  typedef struct packed {
    logic                     is_tick;
    logic                     strobe;
    logic [DistW-1:0]         distance;
    logic signed [PropW-1:0]  prop;
    logic signed [ProdW-1:0]  prod_hold;
    logic signed [ProdW-1:0]  prod_step;
    logic signed [IntegW-1:0] sum_step;
  } erpmd_stage_t;

endpackage

@@ design/erpmd_ifs.sv @@
// ----------------------------------------------------------------------------
// erpmd interfaces
// Valid/ready channels for event requests and drive result requests.
// ----------------------------------------------------------------------------
interface erpmd_in_if;
  import erpmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic              echo_level;
  logic [TimeW-1:0]  capture_time;

  modport source (output valid, mode, echo_level, capture_time, input ready);
  modport sink   (input valid, mode, echo_level, capture_time, output ready);
endinterface

interface erpmd_out_if;
  import erpmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DistW-1:0]  distance_cm;
  logic [LevelW-1:0] drive_forward;
  logic [LevelW-1:0] drive_reverse;
  logic              drive_write;

  modport source (output valid, distance_cm, drive_forward, drive_reverse, drive_write,
                  input ready);
  modport sink   (input valid, distance_cm, drive_forward, drive_reverse, drive_write,
                  output ready);
endinterface

@@ design/echo_ranging_pi_motor_drive.sv @@
// ----------------------------------------------------------------------------
// echo_ranging_pi_motor_drive
// Pipeline: an accepted request loads the front stage register, then the
// result register once that is empty or its result is taken.
// Throughput: one request per cycle unless the result channel stalls; the
// integral rail check is resolved in the drive stage while the next tick is
// prepared for both outcomes.
// Reset: rst clears all event and controller state and loads the register
// defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module echo_ranging_pi_motor_drive #(
  parameter int unsigned OVERFLOW_WEIGHT = 65536,
  parameter int unsigned TICKS_PER_US    = 2,
  parameter int unsigned US_PER_CM       = 58
) (
  input  logic                          clk,
  input  logic                          rst,
  erpmd_in_if.sink                      echo_in,
  erpmd_out_if.source                   drive_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [erpmd_pkg::AddrW-1:0]   paddr,
  input  logic [erpmd_pkg::DataW-1:0]   pwdata,
  output logic [erpmd_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import erpmd_pkg::*;

  erpmd_cfg_t               cfg;
  erpmd_stage_t             stage;
  logic                     stage_valid;
  logic                     advance;
  logic signed [IntegW-1:0] integ_next;

  // Configuration registers.
  erpmd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Event handling and first half of the PI step.
  erpmd_front #(
    .OVERFLOW_WEIGHT (OVERFLOW_WEIGHT),
    .TICKS_PER_US    (TICKS_PER_US),
    .US_PER_CM       (US_PER_CM)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .echo_in     (echo_in),
    .cfg         (cfg),
    .integ_next  (integ_next),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // Drive output and result register.
  erpmd_drive u_drive (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .advance     (advance),
    .integ_next  (integ_next),
    .drive_out   (drive_out)
  );

endmodule

@@ design/erpmd_cfg.sv @@
// ----------------------------------------------------------------------------
// erpmd_cfg
// APB register file holding setpoint, drive enable and the two PI gains.
// ----------------------------------------------------------------------------
module erpmd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [erpmd_pkg::AddrW-1:0]   paddr,
  input  logic [erpmd_pkg::DataW-1:0]   pwdata,
  output logic [erpmd_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output erpmd_pkg::erpmd_cfg_t         cfg
);
  import erpmd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[AddrW-1:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= SetpointReset;
      cfg.enable   <= 1'b0;
      cfg.gain_p   <= GainPReset;
      cfg.gain_i   <= GainIReset;
    end else if (wr_en) begin
      unique case (reg_index)
        RegSetpoint: cfg.setpoint <= pwdata[DistW-1:0];
        RegEnable:   cfg.enable   <= pwdata[0];
        RegGainP:    cfg.gain_p   <= pwdata[GainW-1:0];
        RegGainI:    cfg.gain_i   <= pwdata[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_index)
      RegSetpoint: prdata = DataW'(cfg.setpoint);
      RegEnable:   prdata = DataW'(cfg.enable);
      RegGainP:    prdata = DataW'(cfg.gain_p);
      RegGainI:    prdata = DataW'(cfg.gain_i);
      default:     prdata = '0;
    endcase
  end

endmodule

@@ design/erpmd_front.sv @@
// ----------------------------------------------------------------------------
// erpmd_front
// Input stage: echo timing, overflow count and distance state, plus the
// first half of the PI step (error, proportional term, integral candidates).
// ----------------------------------------------------------------------------
module erpmd_front #(
  parameter int unsigned OVERFLOW_WEIGHT = 65536,
  parameter int unsigned TICKS_PER_US    = 2,
  parameter int unsigned US_PER_CM       = 58
) (
  input  logic                                 clk,
  input  logic                                 rst,
  erpmd_in_if.sink                             echo_in,
  input  erpmd_pkg::erpmd_cfg_t                cfg,
  input  logic signed [erpmd_pkg::IntegW-1:0]  integ_next,
  input  logic                                 advance,
  output logic                                 stage_valid,
  output erpmd_pkg::erpmd_stage_t              stage
);
  import erpmd_pkg::*;

  // Width to centimetres: floor(ticks / Divisor), exact below Limit by a
  // reciprocal multiply, and saturated at Limit and above.
  localparam longint unsigned Divisor   = longint'(TICKS_PER_US) * longint'(US_PER_CM);
  localparam longint unsigned Limit     = 256 * Divisor;
  localparam int unsigned     XW        = $clog2(Limit);
  localparam int unsigned     DistShift = $clog2(Limit * Divisor);
  localparam longint unsigned Recip     = ((64'd1 << DistShift) + Divisor - 1) / Divisor;
  localparam int unsigned     MW        = $clog2(Recip + 1);
  localparam int unsigned     PW        = XW + MW;
  localparam logic [31:0]     OvfWeight = 32'(OVERFLOW_WEIGHT);
  localparam logic [31:0]     TickLimit = 32'(Limit);

  logic [7:0]        overflow_count;
  logic [7:0]        start_overflow;
  logic [TimeW-1:0]  start_time;
  logic [DistW-1:0]  measured_distance;

  logic              accept;
  logic [7:0]        ovf_delta;
  logic [31:0]       ticks;
  logic [PW-1:0]     scaled;
  logic [DistW-1:0]  dist_meas;
  logic [DistW-1:0]  distance_next;
  logic signed [ErrW-1:0]     err;
  logic signed [2*ErrW-1:0]   prop_full;
  logic signed [IntegW:0]     sum_wide;
  logic signed [IntegW-1:0]   sum_sat;
  logic signed [ProdW-1:0]    prod_hold;
  logic signed [ProdW-1:0]    prod_step;
  erpmd_stage_t               stage_next;

  assign echo_in.ready = !stage_valid || advance;
  assign accept        = echo_in.valid && echo_in.ready;

  // Pulse width in timer ticks, modulo 2^32, and its distance.
  assign ovf_delta = overflow_count - start_overflow;
  assign ticks     = 32'(ovf_delta) * OvfWeight + 32'(echo_in.capture_time)
                     - 32'(start_time);
  assign scaled    = PW'(ticks[XW-1:0]) * PW'(Recip);
  assign dist_meas = (ticks >= TickLimit) ? DistMax : scaled[DistShift +: DistW];

  assign distance_next = (echo_in.mode == ModeEcho && echo_in.echo_level)
                         ? dist_meas : measured_distance;

  // Error and proportional term.
  assign err       = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, measured_distance});
  assign prop_full = err * $signed({1'b0, cfg.gain_p});

  // Integral if this tick accumulates, saturated to 32 bits.
  assign sum_wide = {integ_next[IntegW-1], integ_next}
                    + {{(IntegW + 1 - ErrW){err[ErrW-1]}}, err};
  always_comb begin
    if (sum_wide[IntegW] != sum_wide[IntegW-1]) begin
      sum_sat = sum_wide[IntegW] ? IntegMin : IntegMax;
    end else begin
      sum_sat = sum_wide[IntegW-1:0];
    end
  end

  // Integral times gain for both outcomes of the rail check.
  assign prod_hold = integ_next * $signed({1'b0, cfg.gain_i});
  assign prod_step = sum_sat * $signed({1'b0, cfg.gain_i});

  always_comb begin
    stage_next.is_tick   = (echo_in.mode == ModeTick);
    stage_next.strobe    = (echo_in.mode == ModeTick) && cfg.enable;
    stage_next.distance  = distance_next;
    stage_next.prop      = prop_full[PropW-1:0];
    stage_next.prod_hold = prod_hold;
    stage_next.prod_step = prod_step;
    stage_next.sum_step  = sum_sat;
  end

  // Event state updates on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count    <= '0;
      start_overflow    <= '0;
      start_time        <= '0;
      measured_distance <= '0;
    end else if (accept) begin
      case (echo_in.mode)
        ModeEcho: begin
          if (!echo_in.echo_level) begin
            start_time     <= echo_in.capture_time;
            start_overflow <= overflow_count;
          end else begin
            measured_distance <= dist_meas;
          end
        end
        ModeOverflow: overflow_count <= overflow_count + 8'd1;
        default: begin
        end
      endcase
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

@@ design/erpmd_drive.sv @@
// ----------------------------------------------------------------------------
// erpmd_drive
// Output stage: resolves the rail check, finishes the PI output, commits the
// integral and drive levels and holds the result register.
// ----------------------------------------------------------------------------
`include "echo_ranging_pi_motor_drive_macros.svh"

module erpmd_drive (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 stage_valid,
  input  erpmd_pkg::erpmd_stage_t              stage,
  output logic                                 advance,
  output logic signed [erpmd_pkg::IntegW-1:0]  integ_next,
  erpmd_out_if.source                          drive_out
);
  import erpmd_pkg::*;

  logic signed [IntegW-1:0] integral;
  logic [LevelW-1:0]        forward_level;
  logic [LevelW-1:0]        reverse_level;

  logic                     out_valid;
  logic [DistW-1:0]         out_distance;
  logic [LevelW-1:0]        out_forward;
  logic [LevelW-1:0]        out_reverse;
  logic                     out_write;

  logic                      railed;
  logic signed [ProdW-1:0]   prod;
  logic [ProdW-1:0]          prod_mag;
  logic [RecipInW+RecipW-1:0] recip_prod;
  logic [QuotW-1:0]          quot_mag;
  logic signed [QuotW:0]     quot;
  logic signed [DriveW-1:0]  drive_sum;
  logic signed [DriveW-1:0]  drive_neg;
  logic [LevelW-1:0]         fwd_calc;
  logic [LevelW-1:0]         rev_calc;
  logic [LevelW-1:0]         forward_next;
  logic [LevelW-1:0]         reverse_next;

  assign advance = stage_valid && (!out_valid || drive_out.ready);
  assign railed  = (forward_level == LevelMax) || (reverse_level == LevelMax);

  // The integral only moves when neither level sat on its rail.
  assign integ_next = (advance && stage.is_tick && !railed) ? stage.sum_step : integral;

  // Integral term divided by 100, truncated toward zero.
  assign prod       = railed ? stage.prod_hold : stage.prod_step;
  assign prod_mag   = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
  assign recip_prod = (RecipInW+RecipW)'(prod_mag[RecipInW-1:0])
                      * (RecipInW+RecipW)'(RecipHundred);
  assign quot_mag   = (prod_mag >= QuotLimit) ? QuotClamp : recip_prod[RecipShift +: QuotW];
  assign quot       = prod[ProdW-1] ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});

  // Sum, clip to the rails and split by direction.
  assign drive_sum = {{(DriveW - PropW){stage.prop[PropW-1]}}, stage.prop}
                     + {{(DriveW - QuotW - 1){quot[QuotW]}}, quot};
  assign drive_neg = -drive_sum;

  always_comb begin
    if (drive_sum > DriveHigh) begin
      fwd_calc = LevelMax;
      rev_calc = '0;
    end else if (drive_sum < DriveLow) begin
      fwd_calc = '0;
      rev_calc = LevelMax;
    end else if (!drive_sum[DriveW-1]) begin
      fwd_calc = drive_sum[LevelW-1:0];
      rev_calc = '0;
    end else begin
      fwd_calc = '0;
      rev_calc = drive_neg[LevelW-1:0];
    end
  end

  assign forward_next = stage.is_tick ? fwd_calc : forward_level;
  assign reverse_next = stage.is_tick ? rev_calc : reverse_level;

  // Committed controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral      <= '0;
      forward_level <= '0;
      reverse_level <= '0;
    end else begin
      integral <= integ_next;
      if (advance) begin
        forward_level <= forward_next;
        reverse_level <= reverse_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !drive_out.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_distance <= stage.distance;
      out_forward  <= forward_next;
      out_reverse  <= reverse_next;
      out_write    <= stage.strobe;
    end
  end

  assign drive_out.valid         = out_valid;
  assign drive_out.distance_cm   = out_distance;
  assign drive_out.drive_forward = out_forward;
  assign drive_out.drive_reverse = out_reverse;
  assign drive_out.drive_write   = out_write;

  // Only one direction is ever driven.
  `ERPMD_ASSERT_ALWAYS(a_one_direction, (forward_level == '0) || (reverse_level == '0), "both drive levels nonzero")
  // Events other than control ticks leave the drive levels alone.
  `ERPMD_ASSERT_NEXT(a_levels_hold, advance && !stage.is_tick, $stable(forward_level) && $stable(reverse_level), "drive level moved on a non-tick event")
  // A tick taken while a level sits on its rail does not touch the integral.
  `ERPMD_ASSERT_NEXT(a_integral_frozen, advance && stage.is_tick && railed, $stable(integral), "integral moved while railed")

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: echo ranging PI motor drive testbench
// Drives echo edges, timer overflows and control ticks through the event
// channel. A cycle-free model of the ranging and PI logic predicts every
// drive result, and each result is compared field by field. Register
// settings change between phases over the APB port, and both channel ends
// idle at random in several patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erpmd_pkg::*;

  localparam int unsigned OvfWeight  = 65536;
  localparam int unsigned TicksPerUs = 2;
  localparam int unsigned UsPerCm    = 58;
  localparam longint      DriveRail  = 255;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             echo_level;
    logic [TimeW-1:0] capture_time;
  } echo_event_t;

  typedef struct packed {
    logic [DistW-1:0]  distance_cm;
    logic [LevelW-1:0] drive_forward;
    logic [LevelW-1:0] drive_reverse;
    logic              drive_write;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  erpmd_in_if  ev_if ();
  erpmd_out_if res_if ();

  echo_ranging_pi_motor_drive dut (
    .clk       (clk),
    .rst       (rst),
    .echo_in   (ev_if),
    .drive_out (res_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Requests waiting to be driven and drive results still to arrive.
  echo_event_t   pending_events[$];
  drive_result_t expected_drives[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned checked_count  = 0;
  int unsigned pulse_count    = 0;
  int unsigned tick_count     = 0;
  int unsigned strobe_count   = 0;
  int unsigned setting_count  = 0;

  // Register copies held by the predictor.
  logic [DistW-1:0] cfg_setpoint = SetpointReset;
  logic             cfg_enable   = 1'b0;
  logic [GainW-1:0] cfg_gain_p   = GainPReset;
  logic [GainW-1:0] cfg_gain_i   = GainIReset;

  // Ranging and controller state held by the predictor.
  logic [7:0]        st_ovf_count  = '0;
  logic [TimeW-1:0]  st_start_time = '0;
  logic [7:0]        st_start_ovf  = '0;
  logic [DistW-1:0]  st_distance   = '0;
  int                st_integral   = 0;
  logic [LevelW-1:0] st_fwd        = '0;
  logic [LevelW-1:0] st_rev        = '0;

  // Apply one request to the predicted state and return the drive result.
  function automatic drive_result_t predict_drive(input echo_event_t e);
    logic [7:0]    dovf;
    logic [31:0]   ticks;
    logic [31:0]   cm_raw;
    longint        err;
    longint        sum;
    longint        drive;
    drive_result_t r;
    r.drive_write = 1'b0;
    case (e.mode)
      ModeEcho: begin
        if (!e.echo_level) begin
          st_start_time = e.capture_time;
          st_start_ovf  = st_ovf_count;
        end else begin
          // Width in ticks wraps modulo 2^32, so a bad pair reads as huge.
          dovf   = st_ovf_count - st_start_ovf;
          ticks  = 32'(dovf) * OvfWeight + 32'(e.capture_time) - 32'(st_start_time);
          cm_raw = ticks / TicksPerUs / UsPerCm;
          st_distance = (cm_raw > 32'(DistMax)) ? DistMax : cm_raw[7:0];
        end
      end
      ModeOverflow: begin
        st_ovf_count = st_ovf_count + 8'd1;
      end
      ModeTick: begin
        err = longint'(cfg_setpoint) - longint'(st_distance);
        // The integral holds while either drive sits on its rail.
        if (st_fwd != LevelMax && st_rev != LevelMax) begin
          sum = longint'(st_integral) + err;
          if (sum > longint'(IntegMax)) sum = longint'(IntegMax);
          if (sum < longint'(IntegMin)) sum = longint'(IntegMin);
          st_integral = int'(sum);
        end
        drive = err * longint'(cfg_gain_p)
              + (longint'(st_integral) * longint'(cfg_gain_i)) / 100;
        if (drive > DriveRail) drive = DriveRail;
        else if (drive < -DriveRail) drive = -DriveRail;
        if (drive >= 0) begin
          st_fwd = LevelW'(drive);
          st_rev = '0;
        end else begin
          st_fwd = '0;
          st_rev = LevelW'(-drive);
        end
        r.drive_write = cfg_enable;
      end
      default: ;
    endcase
    r.distance_cm   = st_distance;
    r.drive_forward = st_fwd;
    r.drive_reverse = st_rev;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Driver: predicts each accepted request, then offers the next one.
  always @(posedge clk) begin
    echo_event_t seen;
    echo_event_t nxt;
    if (rst) begin
      ev_if.valid <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        seen.mode         = ev_if.mode;
        seen.echo_level   = ev_if.echo_level;
        seen.capture_time = ev_if.capture_time;
        if (seen.mode == ModeEcho && seen.echo_level) pulse_count++;
        if (seen.mode == ModeTick) tick_count++;
        expected_drives.push_back(predict_drive(seen));
      end
      if (!ev_if.valid || ev_if.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_events.pop_front();
          ev_if.valid        <= 1'b1;
          ev_if.mode         <= nxt.mode;
          ev_if.echo_level   <= nxt.echo_level;
          ev_if.capture_time <= nxt.capture_time;
        end else begin
          // Idle cycle: the payload carries noise.
          ev_if.valid        <= 1'b0;
          ev_if.mode         <= ModeW'($urandom_range(3));
          ev_if.echo_level   <= 1'($urandom_range(1));
          ev_if.capture_time <= TimeW'($urandom_range(65535));
        end
      end
    end
  end

  // Monitor: checks each accepted drive result against the oldest prediction.
  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        checked_count++;
        if (res_if.drive_write) strobe_count++;
        if (expected_drives.size() == 0) begin
          report_mismatch("unexpected result, count", checked_count, 0);
        end else begin
          want = expected_drives.pop_front();
          if (res_if.distance_cm !== want.distance_cm)
            report_mismatch("distance_cm", 32'(res_if.distance_cm),
                            32'(want.distance_cm));
          if (res_if.drive_forward !== want.drive_forward)
            report_mismatch("drive_forward", 32'(res_if.drive_forward),
                            32'(want.drive_forward));
          if (res_if.drive_reverse !== want.drive_reverse)
            report_mismatch("drive_reverse", 32'(res_if.drive_reverse),
                            32'(want.drive_reverse));
          if (res_if.drive_write !== want.drive_write)
            report_mismatch("drive_write", 32'(res_if.drive_write),
                            32'(want.drive_write));
        end
      end
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_event(input logic [ModeW-1:0] mode, input logic level,
                            input logic [TimeW-1:0] stamp);
    echo_event_t e;
    e.mode         = mode;
    e.echo_level   = level;
    e.capture_time = stamp;
    pending_events.push_back(e);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic apb_write(input logic [1:0] idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSetpoint: cfg_setpoint = value[DistW-1:0];
      RegEnable:   cfg_enable   = value[0];
      RegGainP:    cfg_gain_p   = value[GainW-1:0];
      RegGainI:    cfg_gain_i   = value[GainW-1:0];
      default: ;
    endcase
  endtask

  // Wait until every request is out and every result has been checked.
  task automatic wait_drained();
    while (pending_events.size() != 0 || ev_if.valid || expected_drives.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed echo pulses followed by ticks, the rest noise.
  task automatic fill_random(input int unsigned target);
    int unsigned      made;
    int unsigned      t0;
    int unsigned      width;
    int unsigned      span;
    int unsigned      extra;
    logic [ModeW-1:0] m;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 70) begin
        t0    = $urandom_range(65535);
        width = ($urandom_range(9) == 0) ? $urandom_range(200000) : $urandom_range(35000);
        span  = t0 + width;
        // An occasional pulse has no start edge or a wrong overflow count.
        if ($urandom_range(19) != 0) begin
          push_event(ModeEcho, 1'b0, TimeW'(t0));
          made++;
        end
        extra = ($urandom_range(9) == 0) ? $urandom_range(2) : 0;
        repeat ((span >> 16) + extra) begin
          push_event(ModeOverflow, 1'($urandom_range(1)), TimeW'($urandom_range(65535)));
          made++;
        end
        push_event(ModeEcho, 1'b1, TimeW'(span));
        made++;
        repeat ($urandom_range(1, 3)) begin
          push_event(ModeTick, 1'($urandom_range(1)), TimeW'($urandom_range(65535)));
          made++;
        end
      end else begin
        m = ModeW'($urandom_range(3));
        push_event(m, 1'($urandom_range(1)), TimeW'($urandom_range(65535)));
        if (m != ModeUnused) made++;
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] sp, input logic en, input logic [7:0] gp,
                           input logic [7:0] gi, input int unsigned src_pct,
                           input int unsigned sink_pct, input int unsigned n);
    wait_drained();
    apb_write(RegSetpoint, DataW'(sp));
    apb_write(RegEnable, DataW'(en));
    apb_write(RegGainP, DataW'(gp));
    apb_write(RegGainI, DataW'(gi));
    setting_count++;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    fill_random(n);
  endtask

  initial begin
    int unsigned t0;
    ev_if.valid        = 1'b0;
    ev_if.mode         = ModeEcho;
    ev_if.echo_level   = 1'b0;
    ev_if.capture_time = '0;
    res_if.ready       = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values, drive disabled.
    push_event(ModeEcho, 1'b1, 16'hFFFF);     // end edge with no start: saturates
    push_event(ModeTick, 1'b0, 16'h0000);     // drive updates while disabled
    push_event(ModeTick, 1'b1, 16'hFFFF);     // reverse rail holds the integral
    push_event(ModeUnused, 1'b1, 16'hA5A5);   // unused mode changes nothing
    push_event(ModeEcho, 1'b0, 16'hFFFF);
    push_event(ModeOverflow, 1'b1, 16'h5A5A);
    push_event(ModeEcho, 1'b1, 16'h0000);     // one tick across an overflow
    push_event(ModeTick, 1'b0, 16'h0000);
    push_event(ModeEcho, 1'b0, 16'd1000);
    push_event(ModeEcho, 1'b1, 16'd999);      // end before start: huge width
    push_event(ModeEcho, 1'b0, 16'd0);
    push_event(ModeEcho, 1'b1, 16'd11600);    // exactly 100 cm, zero error
    push_event(ModeTick, 1'b0, 16'h0000);
    wait_drained();

    // Directed part at the top of every register range.
    apb_write(RegSetpoint, DataW'(255));
    apb_write(RegEnable, DataW'(1));
    apb_write(RegGainP, DataW'(255));
    apb_write(RegGainI, DataW'(255));
    setting_count++;
    push_event(ModeTick, 1'b0, 16'h0000);
    push_event(ModeTick, 1'b1, 16'h0000);     // forward rail holds the integral
    push_event(ModeEcho, 1'b0, 16'h8000);
    push_event(ModeEcho, 1'b1, 16'h8000);     // zero width
    push_event(ModeTick, 1'b0, 16'h0000);
    wait_drained();

    // Directed part with the setpoint at zero: negative error.
    apb_write(RegSetpoint, DataW'(0));
    apb_write(RegGainP, DataW'(0));
    setting_count++;
    push_event(ModeEcho, 1'b0, 16'd0);
    push_event(ModeEcho, 1'b1, 16'd23200);    // 200 cm
    repeat (3) push_event(ModeTick, 1'b0, 16'h0000);

    // Random phases, each with its own register setting and idle pattern.
    run_phase(8'd100, 1'b1, 8'd2, 8'd10, 0, 0, 130);
    // One pulse spanning 256 overflows: the count wraps back to its start.
    t0 = $urandom_range(30000);
    push_event(ModeEcho, 1'b0, TimeW'(t0));
    repeat (256) push_event(ModeOverflow, 1'($urandom_range(1)),
                            TimeW'($urandom_range(65535)));
    push_event(ModeEcho, 1'b1, TimeW'(t0 + $urandom_range(30000)));
    push_event(ModeTick, 1'b0, 16'h0000);
    run_phase(8'd255, 1'b1, 8'd255, 8'd255, 73, 0, 130);
    run_phase(8'd0, 1'b0, 8'd0, 8'd0, 0, 73, 130);
    run_phase(8'($urandom_range(1, 254)), 1'b1, 8'($urandom_range(1, 254)),
              8'($urandom_range(1, 254)), 35, 35, 130);
    wait_drained();

    $display("Checked %0d drive results: %0d echo pulses, %0d control ticks, %0d strobes,",
             checked_count, pulse_count, tick_count, strobe_count);
    $display("over %0d register settings with sender and receiver idling in turn.",
             setting_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Timeout waiting for drive results");
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/erpmd_pkg.sv
design/erpmd_ifs.sv
design/erpmd_cfg.sv
design/erpmd_front.sv
design/erpmd_drive.sv
design/echo_ranging_pi_motor_drive.sv
test/tb.sv
